FILE: hw/rtl/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test pipeline.
package rbst_pkg;

   localparam int DATA_W = 32;
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = DIFF_W + DATA_W;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   localparam data_type SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TEST = 1'b1;

   // Load strobes for the four stages that live inside each axis unit.
   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_en_type;

endpackage

FILE: hw/rtl/rbst_slab_axis.sv
// One axis of the slab test: difference, product, shift and saturate, order.
module rbst_slab_axis #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  rbst_pkg::stage_en_type en,
   input  rbst_pkg::data_type   corner_lo,
   input  rbst_pkg::data_type   corner_hi,
   input  rbst_pkg::data_type   origin,
   input  rbst_pkg::data_type   recip,
   output rbst_pkg::data_type   slab_min,
   output rbst_pkg::data_type   slab_max
);
   import rbst_pkg::*;

   diff_type diff_lo_ff, diff_hi_ff, diff_lo_in, diff_hi_in;
   data_type recip_ff;
   prod_type prod_lo_ff, prod_hi_ff, prod_lo_in, prod_hi_in;
   prod_type shift_lo, shift_hi;
   data_type dist_lo_ff, dist_hi_ff, dist_lo_in, dist_hi_in;
   data_type min_ff, max_ff, min_in, max_in;

   function automatic data_type saturate(input prod_type q);
      logic pos_ovf;
      logic neg_ovf;
      pos_ovf = !q[PROD_W-1] && (|q[PROD_W-2:DATA_W-1]);
      neg_ovf = q[PROD_W-1] && !(&q[PROD_W-2:DATA_W-1]);
      if (pos_ovf) begin
         return SAT_MAX;
      end else if (neg_ovf) begin
         return SAT_MIN;
      end else begin
         return q[DATA_W-1:0];
      end
   endfunction

   // Stage 1: exact 33 bit differences against the current ray origin.
   assign diff_lo_in = DIFF_W'(corner_lo) - DIFF_W'(origin);
   assign diff_hi_in = DIFF_W'(corner_hi) - DIFF_W'(origin);

   // Stage 2: full width signed products.
   assign prod_lo_in = diff_lo_ff * recip_ff;
   assign prod_hi_in = diff_hi_ff * recip_ff;

   // Stage 3: arithmetic shift rounds toward minus infinity, then clamp.
   assign shift_lo   = prod_lo_ff >>> FRAC_BITS;
   assign shift_hi   = prod_hi_ff >>> FRAC_BITS;
   assign dist_lo_in = saturate(shift_lo);
   assign dist_hi_in = saturate(shift_hi);

   // Stage 4: order the two slab distances.
   assign min_in = (dist_lo_ff < dist_hi_ff) ? dist_lo_ff : dist_hi_ff;
   assign max_in = (dist_lo_ff < dist_hi_ff) ? dist_hi_ff : dist_lo_ff;

   always_ff @(posedge clock) begin
      if (en.ld1) begin
         diff_lo_ff <= diff_lo_in;
         diff_hi_ff <= diff_hi_in;
         recip_ff   <= recip;
      end
      if (en.ld2) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (en.ld3) begin
         dist_lo_ff <= dist_lo_in;
         dist_hi_ff <= dist_hi_in;
      end
      if (en.ld4) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign slab_min = min_ff;
   assign slab_max = max_ff;

endmodule

FILE: hw/rtl/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test pipeline.
//
// Usage:
//   req_ channel: one beat per item. req_mode = load stores the ray origin
//   (vec_a) and reciprocal direction (vec_b) and gives no result. req_mode =
//   test carries the box low corner (vec_a), high corner (vec_b) and the
//   near/far limits of the ray parameter; it gives one rsp_ beat.
//   rsp_ channel: rsp_hit is set when the narrowed entry does not exceed the
//   narrowed exit; rsp_entry_dist is the narrowed entry, hit or not.
//   Pipeline: six register stages (difference, multiply, shift/saturate,
//   min/max, two levels of the entry/exit reduction ending in the output
//   register).
//   Throughput: one beat per cycle, load or test, while req_stall is low.
//   A load takes effect for the very next test beat; tests already inside
//   the pipeline carry the old ray.
//   Reset: clears all stage valid bits and the stored ray to zero, so a test
//   before any load uses origin 0 and reciprocal 0.
//   Stall: each stage advances when it is empty or the next stage advances,
//   so bubbles close up; req_stall rises only when every stage holds a beat
//   and rsp_stall is high. A stalled rsp_ beat holds its payload.
module ray_box_slab_test #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  rbst_pkg::data_type req_vec_a_x,
   input  rbst_pkg::data_type req_vec_a_y,
   input  rbst_pkg::data_type req_vec_a_z,
   input  rbst_pkg::data_type req_vec_b_x,
   input  rbst_pkg::data_type req_vec_b_y,
   input  rbst_pkg::data_type req_vec_b_z,
   input  rbst_pkg::data_type req_near_limit,
   input  rbst_pkg::data_type req_far_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output rbst_pkg::data_type rsp_entry_dist
);
   import rbst_pkg::*;

   localparam int NUM_STAGES = 6;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] ready;
   logic                  accept, load_ray, test_beat;
   stage_en_type          en;

   data_type origin_ff [3];
   data_type recip_ff  [3];
   data_type origin_in [3];
   data_type recip_in  [3];

   // Near/far limits ride alongside the axis units for four stages.
   data_type near_ff [4];
   data_type far_ff  [4];

   data_type slab_min [3];
   data_type slab_max [3];

   data_type entry_a_ff, entry_b_ff, exit_a_ff, exit_b_ff;
   data_type entry_a_in, entry_b_in, exit_a_in, exit_b_in;
   data_type entry, exit_dist;
   data_type entry_ff;
   logic     hit_ff, hit_in;

   // Ready chain from the output register back to the input.
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_stall = !ready[0];
   assign accept    = req_valid && ready[0];
   assign load_ray  = accept && (req_mode == MODE_LOAD);
   assign test_beat = accept && (req_mode == MODE_TEST);

   assign en.ld1 = ready[0];
   assign en.ld2 = ready[1];
   assign en.ld3 = ready[2];
   assign en.ld4 = ready[3];

   // Advance valid bits; a stage that is not ready holds its beat.
   always_comb begin
      valid_in = valid_ff;
      if (ready[0]) begin
         valid_in[0] = test_beat;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_comb begin
      origin_in[0] = req_vec_a_x;
      origin_in[1] = req_vec_a_y;
      origin_in[2] = req_vec_a_z;
      recip_in[0]  = req_vec_b_x;
      recip_in[1]  = req_vec_b_y;
      recip_in[2]  = req_vec_b_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            origin_ff[i] <= '0;
            recip_ff[i]  <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (load_ray) begin
            for (int i = 0; i < 3; i++) begin
               origin_ff[i] <= origin_in[i];
               recip_ff[i]  <= recip_in[i];
            end
         end
      end
   end

   // Slab distances per axis; the axis units hold stages one to four.
   rbst_slab_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock     (clock),
      .en        (en),
      .corner_lo (req_vec_a_x),
      .corner_hi (req_vec_b_x),
      .origin    (origin_ff[0]),
      .recip     (recip_ff[0]),
      .slab_min  (slab_min[0]),
      .slab_max  (slab_max[0])
   );

   rbst_slab_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock     (clock),
      .en        (en),
      .corner_lo (req_vec_a_y),
      .corner_hi (req_vec_b_y),
      .origin    (origin_ff[1]),
      .recip     (recip_ff[1]),
      .slab_min  (slab_min[1]),
      .slab_max  (slab_max[1])
   );

   rbst_slab_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
      .clock     (clock),
      .en        (en),
      .corner_lo (req_vec_a_z),
      .corner_hi (req_vec_b_z),
      .origin    (origin_ff[2]),
      .recip     (recip_ff[2]),
      .slab_min  (slab_min[2]),
      .slab_max  (slab_max[2])
   );

   always_ff @(posedge clock) begin
      if (en.ld1) begin
         near_ff[0] <= req_near_limit;
         far_ff[0]  <= req_far_limit;
      end
      for (int k = 1; k < 4; k++) begin
         if (ready[k]) begin
            near_ff[k] <= near_ff[k-1];
            far_ff[k]  <= far_ff[k-1];
         end
      end
   end

   // Stage 5: first level of the entry max and exit min.
   assign entry_a_in = (slab_min[0] > near_ff[3])    ? slab_min[0] : near_ff[3];
   assign entry_b_in = (slab_min[2] > slab_min[1])   ? slab_min[2] : slab_min[1];
   assign exit_a_in  = (slab_max[0] < far_ff[3])     ? slab_max[0] : far_ff[3];
   assign exit_b_in  = (slab_max[2] < slab_max[1])   ? slab_max[2] : slab_max[1];

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         entry_a_ff <= entry_a_in;
         entry_b_ff <= entry_b_in;
         exit_a_ff  <= exit_a_in;
         exit_b_ff  <= exit_b_in;
      end
   end

   // Stage 6: final reduction and hit compare into the output register.
   assign entry     = (entry_b_ff > entry_a_ff) ? entry_b_ff : entry_a_ff;
   assign exit_dist = (exit_b_ff < exit_a_ff) ? exit_b_ff : exit_a_ff;
   assign hit_in    = (entry <= exit_dist);

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         entry_ff <= entry;
         hit_ff   <= hit_in;
      end
   end

   assign rsp_valid      = valid_ff[NUM_STAGES-1];
   assign rsp_hit        = hit_ff;
   assign rsp_entry_dist = entry_ff;

endmodule

FILE: hw/rtl/rbst_checker.sv
// Port-level checks for the slab test pipeline, bound to the top level.
module rbst_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_mode,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_hit,
   input rbst_pkg::data_type rsp_entry_dist
);
   import rbst_pkg::*;

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_entry_dist))
      else $error("rsp beat changed while stalled");

   // Output is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // Input backpressure only when the output is full and stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with room in the pipeline");

   // With no output stall, an accepted test beat comes out on rsp_valid once it has passed the whole pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_mode == MODE_TEST) && !rsp_stall)
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("test beat did not reach rsp in six cycles");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hit        (rsp_hit),
   .rsp_entry_dist (rsp_entry_dist)
);
